FILE: design/pn2d_pkg.sv
// Shared types, constants and gradient function for the 2D gradient noise core.
`default_nettype none
package pn2d_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = 8;
    localparam int HALF_W     = IDX_W - 1;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 24;
    localparam int NOISE_W    = 19;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 24;

    // Fade polynomial terms in Q.16
    localparam logic signed [21:0] FADE_K15 = 22'sd983040;   // 15.0
    localparam logic [19:0]        FADE_K10 = 20'd655360;    // 10.0
    localparam logic [19:0]        ONE_Q    = 20'd65536;     // 1.0
    localparam logic signed [NOISE_W-1:0] NOISE_LIM = 19'sd131072;  // 2.0

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } cmd_t;

    typedef logic [IDX_W-1:0]            perm_t;
    typedef logic [HALF_W-1:0]           half_addr_t;
    typedef logic [FRAC_BITS-1:0]        frac_t;
    typedef logic [FRAC_BITS:0]          weight_t;
    typedef logic signed [FRAC_BITS:0]   offset_t;
    typedef logic signed [NOISE_W-1:0]   noise_t;

    // Table entry i and entry i+1 (mod table size)
    typedef struct packed
    {
        perm_t hi;
        perm_t lo;
    } perm_pair_t;

    // Table load request
    typedef struct packed
    {
        logic  we;
        perm_t idx;
        perm_t val;
    } table_wr_t;

    function automatic noise_t grad(input logic [2:0] h, input offset_t x, input offset_t y);
        noise_t xe;
        noise_t ye;
        noise_t res;
        xe = NOISE_W'(x);
        ye = NOISE_W'(y);
        unique case (h)
            3'd0, 3'd4: res = xe + ye;
            3'd1, 3'd6: res = ye - xe;
            3'd2, 3'd5: res = xe - ye;
            3'd3, 3'd7: res = -xe - ye;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: design/pn2d_perm_mem.sv
// Permutation table: two copies, each banked by index parity, so an adjacent pair reads in a single access.
`default_nettype none
module pn2d_perm_mem
(
    input  wire logic                   clk,
    input  wire pn2d_pkg::table_wr_t    wr,
    input  wire logic                   rd_en,
    input  wire pn2d_pkg::perm_t        x_idx,
    input  wire pn2d_pkg::perm_t        a_idx,
    input  wire pn2d_pkg::perm_t        b_idx,
    output pn2d_pkg::perm_pair_t        x_pair,
    output pn2d_pkg::perm_pair_t        a_pair,
    output pn2d_pkg::perm_pair_t        b_pair
);

    localparam int HALF_DEPTH = pn2d_pkg::TABLE_SIZE / 2;

    // corner copy: one read pair per cycle; hash copy: two read pairs per cycle; reads only while rd_en is high
    pn2d_pkg::perm_t corner_even_mem [HALF_DEPTH];
    pn2d_pkg::perm_t corner_odd_mem  [HALF_DEPTH];
    pn2d_pkg::perm_t hash_even_mem   [HALF_DEPTH];
    pn2d_pkg::perm_t hash_odd_mem    [HALF_DEPTH];

    pn2d_pkg::perm_t xe_reg, xo_reg, ae_reg, ao_reg, be_reg, bo_reg;
    logic            x_lsb_reg, a_lsb_reg, b_lsb_reg;

    pn2d_pkg::half_addr_t wr_addr;
    pn2d_pkg::half_addr_t x_even_addr, a_even_addr, b_even_addr;

    assign wr_addr = wr.idx[pn2d_pkg::IDX_W-1:1];

    // even bank holds entry i (even) or i+1 (odd i), wrapping at the top
    assign x_even_addr = x_idx[pn2d_pkg::IDX_W-1:1] + pn2d_pkg::half_addr_t'(x_idx[0]);
    assign a_even_addr = a_idx[pn2d_pkg::IDX_W-1:1] + pn2d_pkg::half_addr_t'(a_idx[0]);
    assign b_even_addr = b_idx[pn2d_pkg::IDX_W-1:1] + pn2d_pkg::half_addr_t'(b_idx[0]);

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            if (wr.idx[0])
            begin
                corner_odd_mem[wr_addr] <= wr.val;
                hash_odd_mem[wr_addr]   <= wr.val;
            end
            else
            begin
                corner_even_mem[wr_addr] <= wr.val;
                hash_even_mem[wr_addr]   <= wr.val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            xe_reg    <= corner_even_mem[x_even_addr];
            xo_reg    <= corner_odd_mem[x_idx[pn2d_pkg::IDX_W-1:1]];
            ae_reg    <= hash_even_mem[a_even_addr];
            ao_reg    <= hash_odd_mem[a_idx[pn2d_pkg::IDX_W-1:1]];
            be_reg    <= hash_even_mem[b_even_addr];
            bo_reg    <= hash_odd_mem[b_idx[pn2d_pkg::IDX_W-1:1]];
            x_lsb_reg <= x_idx[0];
            a_lsb_reg <= a_idx[0];
            b_lsb_reg <= b_idx[0];
        end
    end

    always_comb
    begin
        x_pair.lo = x_lsb_reg ? xo_reg : xe_reg;
        x_pair.hi = x_lsb_reg ? xe_reg : xo_reg;
        a_pair.lo = a_lsb_reg ? ao_reg : ae_reg;
        a_pair.hi = a_lsb_reg ? ae_reg : ao_reg;
        b_pair.lo = b_lsb_reg ? bo_reg : be_reg;
        b_pair.hi = b_lsb_reg ? be_reg : bo_reg;
    end

endmodule
`default_nettype wire

FILE: design/pn2d_fade.sv
// Three-stage quintic fade 6t^5 - 15t^4 + 10t^3 in fixed point.
`default_nettype none
module pn2d_fade
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire pn2d_pkg::frac_t   t,
    output pn2d_pkg::weight_t      f
);

    localparam int FB = pn2d_pkg::FRAC_BITS;

    // stage a: i = floor(t*(6t-15)) + 10, tt = floor(t*t)
    logic [21:0]         six_t;
    logic signed [21:0]  k_poly;
    logic signed [38:0]  m_prod;
    logic signed [38:0]  i_sum;
    logic [31:0]         tt_prod;

    pn2d_pkg::frac_t     t_a_reg;
    pn2d_pkg::frac_t     tt_a_reg;
    logic [19:0]         i_a_reg;

    // stage b: t3 = floor(tt*t)
    logic [31:0]         t3_prod;
    pn2d_pkg::frac_t     t3_b_reg;
    logic [19:0]         i_b_reg;

    // stage c: f = clamp(floor(t3*i))
    logic [35:0]         f_prod;
    logic [19:0]         f_full;
    pn2d_pkg::weight_t   f_reg;

    assign six_t   = 22'(t) * 22'd6;
    assign k_poly  = $signed(six_t) - pn2d_pkg::FADE_K15;
    assign m_prod  = 39'($signed({1'b0, t})) * 39'(k_poly);
    assign i_sum   = (m_prod >>> FB) + 39'($signed({1'b0, pn2d_pkg::FADE_K10}));
    assign tt_prod = 32'(t) * 32'(t);

    assign t3_prod = 32'(tt_a_reg) * 32'(t_a_reg);

    assign f_prod  = 36'(t3_b_reg) * 36'(i_b_reg);
    assign f_full  = f_prod[FB+19:FB];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_a_reg  <= t;
            tt_a_reg <= tt_prod[2*FB-1:FB];
            i_a_reg  <= i_sum[19:0];
            t3_b_reg <= t3_prod[2*FB-1:FB];
            i_b_reg  <= i_a_reg;
            f_reg    <= (f_full > pn2d_pkg::ONE_Q) ? pn2d_pkg::weight_t'(pn2d_pkg::ONE_Q)
                                                   : f_full[FB:0];
        end
    end

    assign f = f_reg;

endmodule
`default_nettype wire

FILE: design/pn2d_lerp.sv
// Linear blend a + floor(t*(b-a)): product registered, sum on the output.
`default_nettype none
module pn2d_lerp
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire pn2d_pkg::noise_t   a,
    input  wire pn2d_pkg::noise_t   b,
    input  wire pn2d_pkg::weight_t  t,
    output pn2d_pkg::noise_t        y
);

    localparam int PW = pn2d_pkg::NOISE_W + pn2d_pkg::FRAC_BITS + 3;

    logic signed [pn2d_pkg::NOISE_W:0] diff;
    logic signed [PW-1:0]              prod;
    logic signed [PW-1:0]              prod_reg;
    pn2d_pkg::noise_t                  a_reg;
    logic signed [PW-1:0]              sum;

    assign diff = (pn2d_pkg::NOISE_W+1)'(b) - (pn2d_pkg::NOISE_W+1)'(a);
    assign prod = PW'($signed({1'b0, t})) * PW'(diff);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a;
            prod_reg <= prod;
        end
    end

    assign sum = PW'(a_reg) + (prod_reg >>> pn2d_pkg::FRAC_BITS);
    assign y   = sum[pn2d_pkg::NOISE_W-1:0];

endmodule
`default_nettype wire

FILE: design/perlin_noise_2d_core.sv
// Top level of the 2D gradient noise core: table, hash, fade and blend pipeline.
//
//  channel | dir | words                              | notes
//  --------+-----+------------------------------------+-------------------------------
//  s_*     | in  | table load (tuser=0) / eval (=1)   | tdata: index, value, x, y
//  m_*     | out | one noise word per eval word       | signed Q2.16 in tdata[18:0]
//
//  Throughput: one word per cycle while s_tready is high, loads and evaluates mixed freely.
//  Path from eval accept to m_tvalid: corner table read, hash table read, gradients,
//  then two blend multiplies in series and the output register; fade runs alongside.
//  A load writes both table copies at its accept edge; any later eval sees it.
//  Reset clears the pipeline valids and the output and skid valids only; the table is
//  undefined until loaded.
//  Stalls: a skid stage behind the output register absorbs one word; s_tready
//  drops only while the skid holds a word, and then the whole pipeline freezes.
`default_nettype none
module perlin_noise_2d_core
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [7:0] table_index, [15:8] table_value, [39:16] x_coord, [63:40] y_coord
    input  wire logic [pn2d_pkg::IN_DATA_W-1:0]      s_tdata,
    // [0] cmd
    input  wire logic                                s_tuser,

    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [18:0] noise_value, [23:19] zero
    output logic [pn2d_pkg::OUT_DATA_W-1:0]          m_tdata
);

    localparam int FB     = pn2d_pkg::FRAC_BITS;
    localparam int X_LSB  = 16;
    localparam int Y_LSB  = X_LSB + pn2d_pkg::COORD_W;
    localparam int STAGES = 6;

    // input field split
    pn2d_pkg::perm_t  in_index, in_value, x_int, y_int;
    pn2d_pkg::frac_t  x_frac, y_frac;
    pn2d_pkg::cmd_t   in_cmd;

    assign in_index = s_tdata[7:0];
    assign in_value = s_tdata[15:8];
    assign x_frac   = s_tdata[X_LSB+FB-1:X_LSB];
    assign x_int    = s_tdata[X_LSB+pn2d_pkg::COORD_W-1:X_LSB+FB];
    assign y_frac   = s_tdata[Y_LSB+FB-1:Y_LSB];
    assign y_int    = s_tdata[Y_LSB+pn2d_pkg::COORD_W-1:Y_LSB+FB];
    assign in_cmd   = pn2d_pkg::cmd_t'(s_tuser);

    // global pipeline advance: frozen only while the skid is occupied
    logic advance;
    logic accept;
    logic skid_valid_reg, skid_valid_next;
    logic main_valid_reg, main_valid_next;
    pn2d_pkg::noise_t main_data_reg, main_data_next;
    pn2d_pkg::noise_t skid_data_reg, skid_data_next;

    assign advance  = !skid_valid_reg;
    assign s_tready = advance;
    assign accept   = s_tvalid && s_tready;

    // eval valid per stage, bit k = stage k+1
    logic [STAGES-1:0] vld_reg, vld_next;

    always_comb
    begin
        vld_next = vld_reg;
        if (advance)
        begin
            vld_next = {vld_reg[STAGES-2:0], accept && (in_cmd == pn2d_pkg::CMD_EVAL)};
        end
    end

    // permutation table
    pn2d_pkg::table_wr_t  tbl_wr;
    pn2d_pkg::perm_pair_t x_pair, a_pair, b_pair;
    pn2d_pkg::perm_t      a_idx, b_idx;

    assign tbl_wr.we  = accept && (in_cmd == pn2d_pkg::CMD_LOAD);
    assign tbl_wr.idx = in_index;
    assign tbl_wr.val = in_value;

    pn2d_perm_mem u_perm
    (
        .clk    (clk),
        .wr     (tbl_wr),
        .rd_en  (advance),
        .x_idx  (x_int),
        .a_idx  (a_idx),
        .b_idx  (b_idx),
        .x_pair (x_pair),
        .a_pair (a_pair),
        .b_pair (b_pair)
    );

    // fade weights, ready in stage 3
    pn2d_pkg::weight_t u_w, v_w;

    pn2d_fade u_fade_x
    (
        .clk (clk),
        .en  (advance),
        .t   (x_frac),
        .f   (u_w)
    );

    pn2d_fade u_fade_y
    (
        .clk (clk),
        .en  (advance),
        .t   (y_frac),
        .f   (v_w)
    );

    // stage 1: corner entries back, form hash addresses (wrap mod table size)
    pn2d_pkg::frac_t xf_s1_reg, yf_s1_reg, xf_s2_reg, yf_s2_reg;
    pn2d_pkg::perm_t yi_s1_reg;

    assign a_idx = x_pair.lo + yi_s1_reg;
    assign b_idx = x_pair.hi + yi_s1_reg;

    // stage 2: hashes back, gradient per corner; far corner offset is f - 1.0
    pn2d_pkg::offset_t x0, x1, y0, y1;
    pn2d_pkg::noise_t  g00_s3_reg, g10_s3_reg, g01_s3_reg, g11_s3_reg;

    assign x0 = $signed({1'b0, xf_s2_reg});
    assign x1 = $signed({1'b1, xf_s2_reg});
    assign y0 = $signed({1'b0, yf_s2_reg});
    assign y1 = $signed({1'b1, yf_s2_reg});

    // stages 3-4: blend along x
    pn2d_pkg::noise_t  lx0, lx1;
    pn2d_pkg::noise_t  l1_s5_reg, l2_s5_reg;
    pn2d_pkg::weight_t v_s4_reg, v_s5_reg;

    pn2d_lerp u_lerp_lo
    (
        .clk (clk),
        .en  (advance),
        .a   (g00_s3_reg),
        .b   (g10_s3_reg),
        .t   (u_w),
        .y   (lx0)
    );

    pn2d_lerp u_lerp_hi
    (
        .clk (clk),
        .en  (advance),
        .a   (g01_s3_reg),
        .b   (g11_s3_reg),
        .t   (u_w),
        .y   (lx1)
    );

    // stages 5-6: blend along y
    pn2d_pkg::noise_t ly;
    pn2d_pkg::noise_t res;
    logic             res_valid;

    pn2d_lerp u_lerp_y
    (
        .clk (clk),
        .en  (advance),
        .a   (l1_s5_reg),
        .b   (l2_s5_reg),
        .t   (v_s5_reg),
        .y   (ly)
    );

    always_comb
    begin
        priority if (ly > pn2d_pkg::NOISE_LIM)
        begin
            res = pn2d_pkg::NOISE_LIM;
        end
        else if (ly < -pn2d_pkg::NOISE_LIM)
        begin
            res = -pn2d_pkg::NOISE_LIM;
        end
        else
        begin
            res = ly;
        end
    end

    assign res_valid = vld_reg[STAGES-1] && advance;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            xf_s1_reg  <= x_frac;
            yf_s1_reg  <= y_frac;
            yi_s1_reg  <= y_int;
            xf_s2_reg  <= xf_s1_reg;
            yf_s2_reg  <= yf_s1_reg;
            g00_s3_reg <= pn2d_pkg::grad(a_pair.lo[2:0], x0, y0);
            g10_s3_reg <= pn2d_pkg::grad(b_pair.lo[2:0], x1, y0);
            g01_s3_reg <= pn2d_pkg::grad(a_pair.hi[2:0], x0, y1);
            g11_s3_reg <= pn2d_pkg::grad(b_pair.hi[2:0], x1, y1);
            v_s4_reg   <= v_w;
            v_s5_reg   <= v_s4_reg;
            l1_s5_reg  <= lx0;
            l2_s5_reg  <= lx1;
        end
    end

    // output register with skid
    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || m_tready)
        begin
            main_valid_next = skid_valid_reg || res_valid;
            main_data_next  = skid_valid_reg ? skid_data_reg : res;
            skid_valid_next = 1'b0;
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg        <= vld_next;
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = pn2d_pkg::OUT_DATA_W'($unsigned(main_data_reg));

`ifndef SYNTHESIS
    // skid only ever holds a word behind an occupied output register
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds a word while output register is empty");

    // skid fills only from a stalled output
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(main_valid_reg && !m_tready))
        else $error("skid filled without an output stall");

    // noise stays within +/-2.0
    a_noise_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (main_data_reg <= pn2d_pkg::NOISE_LIM &&
                      main_data_reg >= -pn2d_pkg::NOISE_LIM))
        else $error("noise value out of range");

    // a result leaving the pipeline is never dropped
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (main_valid_reg || skid_valid_reg))
        else $error("pipeline result lost");
`endif

endmodule
`default_nettype wire
